@@ src/spd_pkg.sv @@
// Types and constants shared by the stereo ping-pong delay.
// No dependencies; imported by the multiplier unit and the top level.
`default_nettype none

package spd_pkg;

	localparam int DELAY_W = 17;
	localparam int FB_W = 16;
	localparam int WET_W = 17;
	localparam int B0_W = 29;
	localparam int COEF_W = 32;
	localparam int CW = 33;
	localparam int ST_W = 40;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int FB_MAX = 62259;
	localparam int WET_ONE = 65536;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEFT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_RIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CROSS_FEEDBACK = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LPF_B0 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LPF_A1 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LPF_A2 = 3'd7;

	localparam logic [DELAY_W-1:0] DELAY_RST = 17'd12000;
	localparam logic [FB_W-1:0] FB_RST = 16'd26214;
	localparam logic [WET_W-1:0] WET_RST = 17'd32768;
	localparam logic [B0_W-1:0] B0_RST = 29'd268435456;

	localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
	localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

	typedef enum logic [2:0] {
		A_B0,
		A_A1,
		A_A2,
		A_FB,
		A_DRY,
		A_WET
	} a_sel_t;

	typedef enum logic [1:0] {
		B_FED,
		B_Y,
		B_SMP,
		B_DEL
	} b_sel_t;

	typedef struct packed {
		logic issue;
		a_sel_t a_sel;
		b_sel_t b_sel;
	} mul_ctrl_t;

	typedef struct packed {
		logic [B0_W-1:0] b0;
		logic [COEF_W-1:0] a1;
		logic [COEF_W-1:0] a2;
		logic [FB_W-1:0] fb;
		logic [WET_W-1:0] wet;
	} coef_t;

endpackage

`default_nettype wire

@@ src/spd_if.sv @@
// Stream interfaces for the stereo sample requests in and the mixed results out.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface spd_in_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic signed [W-1:0] left_in;
	logic signed [W-1:0] right_in;
	modport source (output valid, left_in, right_in, input ready);
	modport sink (input valid, left_in, right_in, output ready);
endinterface

interface spd_out_if #(parameter int W = 24);
	logic valid;
	logic ready;
	logic signed [W-1:0] left_out;
	logic signed [W-1:0] right_out;
	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

`default_nettype wire

@@ src/spd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the delay lines.
`default_nettype none

module spd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ src/spd_mul.sv @@
// Shared signed multiplier with operand selection and a registered product.
// Depends on spd_pkg for the operand select codes and the coefficient bundle.
`default_nettype none

module spd_mul import spd_pkg::*; #(
	parameter int SB = 24
) (
	input  logic                        clk,
	input  mul_ctrl_t                   ctrl,
	input  coef_t                       coef,
	input  logic signed [SB-1:0]        fed,
	input  logic signed [SB-1:0]        y,
	input  logic signed [SB-1:0]        smp,
	input  logic signed [SB-1:0]        del,
	output logic signed [CW+SB-1:0]     prod
);

	logic signed [CW-1:0] a_op;
	logic signed [SB-1:0] b_op;
	logic signed [CW+SB-1:0] prod_s1;

	always_comb begin
		case (ctrl.a_sel)
			A_B0: a_op = $signed(CW'(coef.b0));
			A_A1: a_op = CW'($signed(coef.a1));
			A_A2: a_op = CW'($signed(coef.a2));
			A_FB: a_op = $signed(CW'(coef.fb));
			A_DRY: a_op = $signed(CW'(WET_ONE) - CW'(coef.wet));
			A_WET: a_op = $signed(CW'(coef.wet));
			default: a_op = '0;
		endcase
	end

	always_comb begin
		case (ctrl.b_sel)
			B_FED: b_op = fed;
			B_Y: b_op = y;
			B_SMP: b_op = smp;
			B_DEL: b_op = del;
			default: b_op = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			prod_s1 <= a_op * b_op;
		end
	end

	assign prod = prod_s1;

endmodule

`default_nettype wire

@@ src/stereo_ping_pong_delay.sv @@
// Stereo ping-pong feedback delay: top level with configuration, sequencer and delay lines.
// Depends on spd_pkg, spd_if, spd_ram and spd_mul.
//
//   channel   | dir | handshake      | payload
//   audio     | in  | valid/ready    | left_in, right_in
//   mix       | out | valid/ready    | left_out, right_out
//   cfg       | in  | cfg_we         | cfg_idx, cfg_data
//
// An accepted request is finished before the next one can be accepted: one shared
// multiplier forms twelve products for the left, then the right channel, then a write
// state and an output state follow. Ready stays low while a request is in work and while
// the result waits for a full output register. Reset needs no clearing pass; entries not
// yet written since reset read as zero through a fill flag and the write pointer.
`default_nettype none

module stereo_ping_pong_delay import spd_pkg::*; #(
	parameter int MAX_DELAY = 131072,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	spd_in_if.sink                audio,
	spd_out_if.source             mix,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SB = SAMPLE_BITS;
	localparam int AW = $clog2(MAX_DELAY);
	localparam int PW = CW + SB;
	localparam int SUM_W = PW + 1;
	localparam int BX_W = PW - 20;
	localparam int B1_W = PW - 19;
	localparam int QMAX = (2 ** DELAY_W - 1) / MAX_DELAY;
	localparam int QBITS = $clog2(QMAX + 1);
	localparam logic [AW:0] MAX_W = (AW + 1)'(MAX_DELAY);
	localparam logic [AW-1:0] WP_LAST = AW'(MAX_DELAY - 1);
	localparam logic signed [SUM_W-1:0] SMP_MAX = SUM_W'((64'sd1 <<< (SB - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SMP_MIN = SUM_W'(-(64'sd1 <<< (SB - 1)));

	localparam logic [2:0] STEP_B0X = 3'd0;
	localparam logic [2:0] STEP_Y = 3'd1;
	localparam logic [2:0] STEP_A1Y = 3'd2;
	localparam logic [2:0] STEP_A2Y = 3'd3;
	localparam logic [2:0] STEP_FBY = 3'd4;
	localparam logic [2:0] STEP_DRY = 3'd5;
	localparam logic [2:0] STEP_WET = 3'd6;
	localparam logic [2:0] STEP_MIX = 3'd7;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_WRITE,
		S_DONE
	} state_t;

	function automatic logic [AW-1:0] reduce_delay(input logic [DELAY_W-1:0] d);
		int r;
		r = int'(d);
		for (int k = QBITS - 1; k >= 0; k--) begin
			if (r >= (MAX_DELAY << k)) begin
				r = r - (MAX_DELAY << k);
			end
		end
		return r[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] rd_index(input logic [AW-1:0] wp,
	                                           input logic [AW-1:0] dm);
		if (wp >= dm) begin
			return wp - dm;
		end
		return AW'({1'b0, wp} + MAX_W - {1'b0, dm});
	endfunction

	function automatic logic signed [SB-1:0] sat_smp(input logic signed [SUM_W-1:0] v);
		if (v > SMP_MAX) begin
			return SMP_MAX[SB-1:0];
		end
		if (v < SMP_MIN) begin
			return SMP_MIN[SB-1:0];
		end
		return v[SB-1:0];
	endfunction

	function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(ST_MAX)) begin
			return ST_MAX;
		end
		if (v < SUM_W'(ST_MIN)) begin
			return ST_MIN;
		end
		return v[ST_W-1:0];
	endfunction

	state_t state_q;
	logic [2:0] step_q;
	logic ch_q;

	logic [AW-1:0] dly_l_q;
	logic [AW-1:0] dly_r_q;
	logic cross_q;
	coef_t coef_q;

	logic [AW-1:0] wp_q;
	logic full_q;
	logic vld_q [2];

	logic signed [SB-1:0] in_q [2];
	logic signed [SB-1:0] fbk_q [2];
	logic signed [ST_W-1:0] s1_q [2];
	logic signed [ST_W-1:0] s2_q [2];
	logic signed [SB-1:0] t_q [2];
	logic signed [SB-1:0] o_q [2];
	logic signed [SB-1:0] y_q;
	logic signed [BX_W-1:0] bx_q;
	logic signed [B1_W-1:0] b1x_q;
	logic signed [PW-1:0] acc_q;

	logic out_v_q;
	logic signed [SB-1:0] out_l_q;
	logic signed [SB-1:0] out_r_q;

	logic accept;
	logic [AW-1:0] rd_l;
	logic [AW-1:0] rd_r;
	logic [SB-1:0] rdata_l;
	logic [SB-1:0] rdata_r;
	logic signed [SB-1:0] del_l;
	logic signed [SB-1:0] del_r;
	logic signed [SB-1:0] del_c;
	logic mem_we;
	logic signed [SB-1:0] wdata_l;
	logic signed [SB-1:0] wdata_r;

	mul_ctrl_t mctl;
	logic signed [PW-1:0] prod;
	logic signed [SUM_W-1:0] p_ext;
	logic signed [SUM_W-1:0] y_sum;
	logic signed [SUM_W-1:0] s1_sum;
	logic signed [SUM_W-1:0] s2_sum;
	logic signed [SUM_W-1:0] o_sum;
	logic signed [SUM_W-1:0] w_sum_l;
	logic signed [SUM_W-1:0] w_sum_r;
	logic signed [SB-1:0] t_new;

	assign accept = audio.valid && audio.ready;
	assign audio.ready = (state_q == S_IDLE);

	assign rd_l = rd_index(wp_q, dly_l_q);
	assign rd_r = rd_index(wp_q, dly_r_q);

	assign del_l = vld_q[0] ? $signed(rdata_l) : '0;
	assign del_r = vld_q[1] ? $signed(rdata_r) : '0;
	assign del_c = ch_q ? del_r : del_l;

	assign p_ext = SUM_W'(prod);
	assign y_sum = (p_ext >>> 20) + SUM_W'(s1_q[ch_q]);
	assign s1_sum = SUM_W'(b1x_q) - (p_ext >>> 20) + SUM_W'(s2_q[ch_q]);
	assign s2_sum = SUM_W'(bx_q) - (p_ext >>> 20);
	assign t_new = SB'(p_ext >>> 16);
	assign o_sum = SUM_W'(acc_q) + p_ext;

	assign w_sum_l = SUM_W'(in_q[0]) + SUM_W'(cross_q ? t_q[1] : t_q[0]);
	assign w_sum_r = SUM_W'(in_q[1]) + SUM_W'(cross_q ? t_q[0] : t_q[1]);
	assign wdata_l = sat_smp(w_sum_l);
	assign wdata_r = sat_smp(w_sum_r);
	assign mem_we = (state_q == S_WRITE);

	always_comb begin
		mctl.issue = 1'b0;
		mctl.a_sel = A_B0;
		mctl.b_sel = B_FED;
		if (state_q == S_RUN) begin
			case (step_q)
				STEP_B0X: begin
					mctl.issue = 1'b1;
					mctl.a_sel = A_B0;
					mctl.b_sel = B_FED;
				end
				STEP_A1Y: begin
					mctl.issue = 1'b1;
					mctl.a_sel = A_A1;
					mctl.b_sel = B_Y;
				end
				STEP_A2Y: begin
					mctl.issue = 1'b1;
					mctl.a_sel = A_A2;
					mctl.b_sel = B_Y;
				end
				STEP_FBY: begin
					mctl.issue = 1'b1;
					mctl.a_sel = A_FB;
					mctl.b_sel = B_Y;
				end
				STEP_DRY: begin
					mctl.issue = 1'b1;
					mctl.a_sel = A_DRY;
					mctl.b_sel = B_SMP;
				end
				STEP_WET: begin
					mctl.issue = 1'b1;
					mctl.a_sel = A_WET;
					mctl.b_sel = B_DEL;
				end
				default: begin
					mctl.issue = 1'b0;
				end
			endcase
		end
	end

	spd_mul #(.SB(SB)) u_mul (
		.clk  (clk),
		.ctrl (mctl),
		.coef (coef_q),
		.fed  (fbk_q[ch_q]),
		.y    (y_q),
		.smp  (in_q[ch_q]),
		.del  (del_c),
		.prod (prod)
	);

	spd_ram #(.WIDTH(SB), .DEPTH(MAX_DELAY)) u_ram_l (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (wdata_l),
		.re    (accept),
		.raddr (rd_l),
		.rdata (rdata_l)
	);

	spd_ram #(.WIDTH(SB), .DEPTH(MAX_DELAY)) u_ram_r (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wp_q),
		.wdata (wdata_r),
		.re    (accept),
		.raddr (rd_r),
		.rdata (rdata_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_l_q <= reduce_delay(DELAY_RST);
			dly_r_q <= reduce_delay(DELAY_RST);
			coef_q.fb <= FB_RST;
			coef_q.wet <= WET_RST;
			cross_q <= 1'b0;
			coef_q.b0 <= B0_RST;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DELAY_LEFT: dly_l_q <= reduce_delay(cfg_data[DELAY_W-1:0]);
				REG_DELAY_RIGHT: dly_r_q <= reduce_delay(cfg_data[DELAY_W-1:0]);
				REG_FEEDBACK_GAIN: begin
					if (cfg_data[FB_W-1:0] > FB_W'(FB_MAX)) begin
						coef_q.fb <= FB_W'(FB_MAX);
					end else begin
						coef_q.fb <= cfg_data[FB_W-1:0];
					end
				end
				REG_WET_GAIN: begin
					if (cfg_data[WET_W-1:0] > WET_W'(WET_ONE)) begin
						coef_q.wet <= WET_W'(WET_ONE);
					end else begin
						coef_q.wet <= cfg_data[WET_W-1:0];
					end
				end
				REG_CROSS_FEEDBACK: cross_q <= cfg_data[0];
				REG_LPF_B0: coef_q.b0 <= cfg_data[B0_W-1:0];
				REG_LPF_A1: coef_q.a1 <= cfg_data[COEF_W-1:0];
				REG_LPF_A2: coef_q.a2 <= cfg_data[COEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= STEP_B0X;
			ch_q <= 1'b0;
			wp_q <= '0;
			full_q <= 1'b0;
			vld_q[0] <= 1'b0;
			vld_q[1] <= 1'b0;
			fbk_q[0] <= '0;
			fbk_q[1] <= '0;
			s1_q[0] <= '0;
			s1_q[1] <= '0;
			s2_q[0] <= '0;
			s2_q[1] <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (mix.ready && state_q != S_DONE) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (audio.valid) begin
						in_q[0] <= audio.left_in;
						in_q[1] <= audio.right_in;
						vld_q[0] <= full_q || (rd_l < wp_q);
						vld_q[1] <= full_q || (rd_r < wp_q);
						step_q <= STEP_B0X;
						ch_q <= 1'b0;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						STEP_Y: begin
							bx_q <= BX_W'(p_ext >>> 20);
							b1x_q <= B1_W'(p_ext >>> 19);
							y_q <= sat_smp(y_sum >>> 8);
						end
						STEP_A2Y: s1_q[ch_q] <= sat_st(s1_sum);
						STEP_FBY: s2_q[ch_q] <= sat_st(s2_sum);
						STEP_DRY: t_q[ch_q] <= t_new;
						STEP_WET: acc_q <= prod;
						STEP_MIX: begin
							o_q[ch_q] <= sat_smp(o_sum >>> 16);
							if (ch_q) begin
								state_q <= S_WRITE;
							end else begin
								ch_q <= 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				S_WRITE: begin
					fbk_q[0] <= del_l;
					fbk_q[1] <= del_r;
					if (wp_q == WP_LAST) begin
						wp_q <= '0;
						full_q <= 1'b1;
					end else begin
						wp_q <= wp_q + AW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_v_q || mix.ready) begin
						out_l_q <= o_q[0];
						out_r_q <= o_q[1];
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign mix.valid = out_v_q;
	assign mix.left_out = out_l_q;
	assign mix.right_out = out_r_q;

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("Fill flag dropped after the delay lines were filled.");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= WP_LAST)
		else $error("Write pointer left the delay line.");

	a_wp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_WRITE |=> $stable(wp_q))
		else $error("Write pointer moved outside the write cycle.");

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (rd_l <= WP_LAST && rd_r <= WP_LAST))
		else $error("Read index outside the delay line.");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(state_q == S_DONE))
		else $error("Result presented without a finished request.");

endmodule

`default_nettype wire

@@ verif/tb_stereo_ping_pong_delay.sv @@
// Self-checking testbench for the stereo ping-pong feedback delay.
// Uses spd_pkg and the stream interfaces of spd_if; a predictor with its own delay
// memories and lowpass state gives the untyped expected pairs; all are checked in order.
`default_nettype none

module tb_stereo_ping_pong_delay import spd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 131072;
	localparam longint SMP_MAX = 64'sd8388607;
	localparam longint SMP_MIN = -64'sd8388608;
	localparam int PHASES = 8;
	localparam int PHASE_PAIRS = 250;

	typedef logic [7:0][CFG_DATA_W-1:0] reg_file_t;

	typedef struct packed {
		logic signed [23:0] l;
		logic signed [23:0] r;
	} stereo_t;

	typedef struct packed {
		logic is_setting;
		logic [1:0] setting_no;
		logic signed [23:0] l;
		logic signed [23:0] r;
		logic typed;
		logic signed [23:0] exp_l;
		logic signed [23:0] exp_r;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	spd_in_if #(.W(24)) audio_ch ();
	spd_out_if #(.W(24)) mix_ch ();

	stereo_ping_pong_delay dut (
		.clk(clk),
		.arst_n(arst_n),
		.audio(audio_ch),
		.mix(mix_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("tb_stereo_ping_pong_delay NOT OK");
		$finish;
	end

	int dly_l = DELAY_RST;
	int dly_r = DELAY_RST;
	int fb_gain = FB_RST;
	int wet_gain = WET_RST;
	bit cross_fb = 1'b0;
	longint lp_b0 = B0_RST;
	longint lp_a1 = 0;
	longint lp_a2 = 0;

	int store_l [DEPTH];
	int store_r [DEPTH];
	int wr_ptr = 0;
	longint fed_l = 0;
	longint fed_r = 0;
	longint lp_s1 [2];
	longint lp_s2 [2];

	stereo_t expected_mix [$];
	int mismatches = 0;
	int mix_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	function automatic longint clip_sample(longint v);
		return v > SMP_MAX ? SMP_MAX : (v < SMP_MIN ? SMP_MIN : v);
	endfunction

	function automatic longint clip_state(longint v);
		return v > ST_MAX ? longint'(ST_MAX) : (v < ST_MIN ? longint'(ST_MIN) : v);
	endfunction

	function automatic void take_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_DELAY_LEFT: dly_l = int'(d[16:0]);
			REG_DELAY_RIGHT: dly_r = int'(d[16:0]);
			REG_FEEDBACK_GAIN: fb_gain = int'(d[15:0]) > FB_MAX ? FB_MAX : int'(d[15:0]);
			REG_WET_GAIN: wet_gain = int'(d[16:0]) > WET_ONE ? WET_ONE : int'(d[16:0]);
			REG_CROSS_FEEDBACK: cross_fb = d[0];
			REG_LPF_B0: lp_b0 = longint'(d[28:0]);
			REG_LPF_A1: lp_a1 = longint'($signed(d));
			REG_LPF_A2: lp_a2 = longint'($signed(d));
			default: ;
		endcase
	endfunction

	function automatic longint lowpass_step(int ch, longint x);
		longint bx;
		longint b1x;
		longint y;
		longint s2_old;
		bx = (lp_b0 * x) >>> 20;
		b1x = (2 * lp_b0 * x) >>> 20;
		y = clip_sample((bx + lp_s1[ch]) >>> 8);
		s2_old = lp_s2[ch];
		lp_s1[ch] = clip_state(b1x - ((lp_a1 * y) >>> 20) + s2_old);
		lp_s2[ch] = clip_state(bx - ((lp_a2 * y) >>> 20));
		return y;
	endfunction

	function automatic stereo_t delay_line_step(logic signed [23:0] l, logic signed [23:0] r);
		longint in_l;
		longint in_r;
		longint del_l;
		longint del_r;
		longint t_l;
		longint t_r;
		longint dry;
		stereo_t mixed;
		in_l = l;
		in_r = r;
		del_l = store_l[(wr_ptr + DEPTH - (dly_l % DEPTH)) % DEPTH];
		del_r = store_r[(wr_ptr + DEPTH - (dly_r % DEPTH)) % DEPTH];
		t_l = (lowpass_step(0, fed_l) * fb_gain) >>> 16;
		t_r = (lowpass_step(1, fed_r) * fb_gain) >>> 16;
		if (cross_fb) begin
			store_l[wr_ptr] = int'(clip_sample(in_l + t_r));
			store_r[wr_ptr] = int'(clip_sample(in_r + t_l));
		end else begin
			store_l[wr_ptr] = int'(clip_sample(in_l + t_l));
			store_r[wr_ptr] = int'(clip_sample(in_r + t_r));
		end
		fed_l = del_l;
		fed_r = del_r;
		dry = WET_ONE - wet_gain;
		mixed.l = 24'(clip_sample((in_l * dry + del_l * wet_gain) >>> 16));
		mixed.r = 24'(clip_sample((in_r * dry + del_r * wet_gain) >>> 16));
		wr_ptr = (wr_ptr + 1) % DEPTH;
		return mixed;
	endfunction

	function automatic reg_file_t make_setting(logic [31:0] dl, logic [31:0] dr, logic [31:0] fb,
			logic [31:0] wet, logic [31:0] cross_en, logic [31:0] b0, logic [31:0] a1,
			logic [31:0] a2);
		reg_file_t v;
		v[REG_DELAY_LEFT] = dl;
		v[REG_DELAY_RIGHT] = dr;
		v[REG_FEEDBACK_GAIN] = fb;
		v[REG_WET_GAIN] = wet;
		v[REG_CROSS_FEEDBACK] = cross_en;
		v[REG_LPF_B0] = b0;
		v[REG_LPF_A1] = a1;
		v[REG_LPF_A2] = a2;
		return v;
	endfunction

	function automatic logic [31:0] random_delay();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'd0 : 32'd131071;
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	function automatic reg_file_t random_setting();
		logic [31:0] fb;
		logic [31:0] wet;
		longint c1;
		longint c2;
		fb = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, FB_MAX);
		case ($urandom_range(0, 5))
			0: wet = $urandom;
			1: wet = WET_ONE;
			2: wet = 32'd0;
			default: wet = $urandom_range(0, WET_ONE);
		endcase
		if ($urandom_range(0, 3) == 0) begin
			return make_setting(random_delay(), random_delay(), fb, wet, $urandom,
				$urandom, $urandom, $urandom);
		end
		c2 = longint'($urandom_range(0, 241591910));
		c1 = -longint'($urandom_range(0, 32'(268435455 + c2)));
		return make_setting(random_delay(), random_delay(), fb, wet, $urandom,
			32'((268435456 + c1 + c2) / 4), 32'(c1), 32'(c2));
	endfunction

	function automatic logic signed [23:0] random_sample();
		case ($urandom_range(0, 7))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom_range(0, 64)) - 24'sd32;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic apply_setting(reg_file_t v);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= CFG_IDX_W'(i);
			cfg_data <= v[i];
			take_register(CFG_IDX_W'(i), v[i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic wait_mix_drained();
		audio_ch.valid <= 1'b0;
		while (expected_mix.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r, logic typed,
			stereo_t typed_mix);
		stereo_t predicted;
		while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			audio_ch.valid <= 1'b0;
			@(posedge clk);
		end
		audio_ch.valid <= 1'b1;
		audio_ch.left_in <= l;
		audio_ch.right_in <= r;
		do
			@(posedge clk);
		while (!audio_ch.ready);
		predicted = delay_line_step(l, r);
		expected_mix.push_back(typed ? typed_mix : predicted);
	endtask

	task automatic report_mismatch(string field, logic signed [23:0] want,
			logic signed [23:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s of output %0d: expected %0d, got %0d",
				field, mix_count, want, got);
	endtask

	always @(posedge clk) begin
		mix_ch.ready <= !(receiver_stall_pct != 0 &&
			$urandom_range(0, 99) < receiver_stall_pct);
	end

	always @(posedge clk) begin
		stereo_t want;
		if (arst_n && mix_ch.valid && mix_ch.ready) begin
			if (expected_mix.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("output %0d arrived with no request pending: %0d %0d",
						mix_count, mix_ch.left_out, mix_ch.right_out);
			end else begin
				want = expected_mix.pop_front();
				if (mix_ch.left_out !== want.l)
					report_mismatch("left_out", want.l, mix_ch.left_out);
				if (mix_ch.right_out !== want.r)
					report_mismatch("right_out", want.r, mix_ch.right_out);
			end
			mix_count++;
		end
	end

	initial begin
		stim_row_t plan [$];
		reg_file_t directed_setting [3];
		logic signed [23:0] smp_l;
		logic signed [23:0] smp_r;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		audio_ch.valid = 1'b0;
		audio_ch.left_in = '0;
		audio_ch.right_in = '0;
		mix_ch.ready = 1'b0;

		directed_setting[0] = make_setting(32'd1, 32'd0, 32'd65535, 32'd131071, 32'd1,
			32'h1FFF_FFFF, 32'd0, 32'd0);
		directed_setting[1] = make_setting(32'd131071, 32'd1, 32'd0, 32'd0, 32'd0,
			32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		directed_setting[2] = make_setting(32'hFFFE_0001, 32'd1, 32'hFFFF_F333, 32'hFFFF_0000,
			32'hFFFF_FFFF, 32'hF000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

		// Right after reset the delayed samples are zero, so the output is half the input.
		plan.push_back(stim_row_t'{1'b0, 2'd0, 24'sh7FFFFF, 24'sh800000, 1'b1,
			24'sh3FFFFF, 24'shC00000});
		plan.push_back(stim_row_t'{1'b0, 2'd0, 24'shFFFFFF, 24'sh000001, 1'b1,
			24'shFFFFFF, 24'sh000000});
		plan.push_back(stim_row_t'{1'b0, 2'd0, 24'sh555555, 24'shAAAAAA, 1'b1,
			24'sh2AAAAA, 24'shD55555});
		plan.push_back(stim_row_t'{1'b0, 2'd0, 24'sh800000, 24'sh7FFFFF, 1'b1,
			24'shC00000, 24'sh3FFFFF});
		plan.push_back(stim_row_t'{1'b0, 2'd0, 24'sh000000, 24'sh000000, 1'b1,
			24'sh000000, 24'sh000000});
		for (int s = 0; s < 3; s++) begin
			plan.push_back(stim_row_t'{1'b1, 2'(s), 24'sh0, 24'sh0, 1'b0, 24'sh0, 24'sh0});
			for (int k = 0; k < 5; k++)
				plan.push_back(stim_row_t'{1'b0, 2'd0, k[0] ? 24'sh800000 : 24'sh7FFFFF,
					k[1] ? 24'sh7FFFFF : 24'sh800000, 1'b0, 24'sh0, 24'sh0});
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			if (plan[k].is_setting) begin
				wait_mix_drained();
				apply_setting(directed_setting[plan[k].setting_no]);
			end else begin
				send_pair(plan[k].l, plan[k].r, plan[k].typed, {plan[k].exp_l, plan[k].exp_r});
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_mix_drained();
			apply_setting(random_setting());
			case (ph % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 76;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 76;
				end
				default: begin
					sender_idle_pct = 37;
					receiver_stall_pct = 37;
				end
			endcase
			for (int n = 0; n < PHASE_PAIRS; n++) begin
				if (ph == 5 && n == PHASE_PAIRS / 2)
					wait_mix_drained();
				smp_l = random_sample();
				smp_r = $urandom_range(0, 3) == 0 ? smp_l : random_sample();
				send_pair(smp_l, smp_r, 1'b0, '0);
			end
		end

		wait_mix_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_mix.size() == 0) begin
			$display("tb_stereo_ping_pong_delay OK");
		end else begin
			$display("tb_stereo_ping_pong_delay NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
